// File: sv/pst_pkg.sv
// ----------------------------------------------------------------------------
// pst_pkg
// Shared types and constants for the priority schedule times block.
// ----------------------------------------------------------------------------
package pst_pkg;

  localparam int ARR_W  = 16;
  localparam int BUR_W  = 16;
  localparam int PRI_W  = 8;
  localparam int NUM_W  = 5;
  localparam int TIME_W = 21;
  localparam int SUM_W  = 25;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

  // One stored job as held in the job table.
  typedef struct packed {
    logic [ARR_W-1:0] arr;
    logic [BUR_W-1:0] bur;
    logic [PRI_W-1:0] pri;
  } job_t;

endpackage

// File: sv/pst_job_ram.sv
// ----------------------------------------------------------------------------
// pst_job_ram
// Job table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pst_job_ram
  import pst_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  job_t          wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output job_t          rd_data_r
);

  job_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

// File: sv/pst_rank_cmp.sv
// ----------------------------------------------------------------------------
// pst_rank_cmp
// Shared compare unit: decides whether a candidate job outranks the best
// job found so far in the current scan.
// ----------------------------------------------------------------------------
module pst_rank_cmp
  import pst_pkg::*;
(
  input  job_t cand,
  input  job_t best,
  input  logic first_pick,
  output logic better
);

  // Candidates arrive in ascending job number, so a full tie keeps the
  // earlier (lower-numbered) job and needs no index compare.
  always_comb begin
    if (first_pick) begin
      better = cand.arr < best.arr;
    end else if (cand.pri != best.pri) begin
      better = cand.pri < best.pri;
    end else begin
      better = cand.arr < best.arr;
    end
  end

endmodule

// File: sv/priority_schedule_times_core.sv
// ----------------------------------------------------------------------------
// priority_schedule_times_core
// Non-preemptive priority scheduler with per-job completion statistics.
// ----------------------------------------------------------------------------
// Jobs are loaded one transfer per cycle and numbered 1, 2, ... in load order;
// a job that arrives while MAX_PROCS jobs are already stored is dropped. The
// transfer that carries last_job starts scheduling, and the block then emits
// one result transfer per stored job in run order. The first job run is the
// earliest arrival (ties to the lower number); every later job is the pending
// one with the lowest priority value, then earliest arrival, then lowest
// number. The job table has a single read port, so each pick scans all the
// stored jobs through one shared compare unit; the completion, turnaround,
// waiting and running-total figures are then worked out one adder step per
// cycle, and the result is held until its transfer completes. Input is not
// taken while a set is being scheduled. After the final result the block
// clears its counters and starts a new set. Completion time saturates at
// 2097151 and the waiting total at 33554431.
// ----------------------------------------------------------------------------
module priority_schedule_times_core
  import pst_pkg::*;
#(
  parameter int MAX_PROCS = 16
) (
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ARR_W-1:0]  in_arrival_time,
  input  logic [BUR_W-1:0]  in_burst_time,
  input  logic [PRI_W-1:0]  in_prio_level,
  input  logic              in_last_job,

  output logic              out_valid,
  input  logic              out_ready,
  output logic [NUM_W-1:0]  out_job_number,
  output logic [ARR_W-1:0]  out_job_arrival,
  output logic [BUR_W-1:0]  out_job_burst,
  output logic [PRI_W-1:0]  out_job_prio,
  output logic [TIME_W-1:0] out_finish_time,
  output logic [TIME_W-1:0] out_turnaround,
  output logic [TIME_W-1:0] out_wait_time,
  output logic [SUM_W-1:0]  out_wait_total,
  output logic              out_last_result
);

  localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W = $clog2(MAX_PROCS + 1);

  typedef enum logic [2:0] {
    S_LOAD,
    S_SCAN,
    S_FIN,
    S_TAT,
    S_WAIT,
    S_SUM,
    S_OUT
  } state_t;

  state_t               state_r;
  logic [CNT_W-1:0]     job_count_r;
  logic [MAX_PROCS-1:0] done_r;
  logic [TIME_W-1:0]    clock_r;
  logic [SUM_W-1:0]     wait_sum_r;
  logic [CNT_W-1:0]     k_r;

  // Scan bookkeeping: issue pointer and the index of the data now returning.
  logic [CNT_W-1:0]     scan_addr_r;
  logic                 rd_vld_r;
  logic [IDX_W-1:0]     rd_idx_r;

  // Best job found so far in the current scan.
  logic                 have_r;
  job_t                 best_r;
  logic [IDX_W-1:0]     best_idx_r;

  logic [TIME_W-1:0]    fin_r;
  logic [TIME_W-1:0]    tat_r;
  logic [TIME_W-1:0]    wt_r;

  logic                 out_valid_r;
  logic [NUM_W-1:0]     out_job_number_r;
  job_t                 out_job_r;
  logic [TIME_W-1:0]    out_finish_r;
  logic [TIME_W-1:0]    out_tat_r;
  logic [TIME_W-1:0]    out_wt_r;
  logic [SUM_W-1:0]     out_sum_r;
  logic                 out_last_r;

  // Table write and read.
  logic                 in_xfer;
  logic                 out_xfer;
  logic                 wr_en;
  job_t                 wr_job;
  job_t                 rd_job;
  logic                 cand_better;

  // Arithmetic steps.
  logic [TIME_W-1:0]    start_time;
  logic [TIME_W:0]      fin_sum;
  logic [TIME_W-1:0]    fin_nxt;
  logic [TIME_W-1:0]    bur_ext;
  logic [SUM_W:0]       sum_wide;
  logic [SUM_W-1:0]     wait_sum_nxt;
  logic [IDX_W:0]       num_wide;
  logic                 last_nxt;

  assign in_ready = (state_r == S_LOAD);
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid_r && out_ready;

  assign wr_en      = in_xfer && (job_count_r < CNT_W'(MAX_PROCS));
  assign wr_job.arr = in_arrival_time;
  assign wr_job.bur = in_burst_time;
  assign wr_job.pri = in_prio_level;

  pst_job_ram #(
    .DEPTH (MAX_PROCS),
    .AW    (IDX_W)
  ) u_job_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (job_count_r[IDX_W-1:0]),
    .wr_data   (wr_job),
    .rd_en     (state_r == S_SCAN),
    .rd_addr   (scan_addr_r[IDX_W-1:0]),
    .rd_data_r (rd_job)
  );

  pst_rank_cmp u_rank_cmp (
    .cand       (rd_job),
    .best       (best_r),
    .first_pick (k_r == '0),
    .better     (cand_better)
  );

  // The first job starts at its arrival; later ones at the later of the
  // previous completion and their own arrival.
  assign start_time = ((k_r == '0) || (clock_r <= TIME_W'(best_r.arr)))
                      ? TIME_W'(best_r.arr) : clock_r;
  assign fin_sum    = {1'b0, start_time} + (TIME_W + 1)'(best_r.bur);
  assign fin_nxt    = (fin_sum > {1'b0, TIME_MAX}) ? TIME_MAX : fin_sum[TIME_W-1:0];
  assign bur_ext    = TIME_W'(best_r.bur);

  assign sum_wide     = {1'b0, wait_sum_r} + (SUM_W + 1)'(wt_r);
  assign wait_sum_nxt = (sum_wide > {1'b0, SUM_MAX}) ? SUM_MAX : sum_wide[SUM_W-1:0];

  assign num_wide = {1'b0, best_idx_r} + (IDX_W + 1)'(1);
  assign last_nxt = ((k_r + CNT_W'(1)) == job_count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      job_count_r <= '0;
      done_r      <= '0;
      clock_r     <= '0;
      wait_sum_r  <= '0;
      k_r         <= '0;
      scan_addr_r <= '0;
      rd_vld_r    <= 1'b0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_LOAD: begin
          if (in_xfer) begin
            if (wr_en) begin
              job_count_r <= job_count_r + CNT_W'(1);
            end
            if (in_last_job) begin
              scan_addr_r <= '0;
              rd_vld_r    <= 1'b0;
              have_r      <= 1'b0;
              state_r     <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          if (scan_addr_r < job_count_r) begin
            scan_addr_r <= scan_addr_r + CNT_W'(1);
            rd_vld_r    <= 1'b1;
            rd_idx_r    <= scan_addr_r[IDX_W-1:0];
          end else begin
            rd_vld_r    <= 1'b0;
          end
          if (rd_vld_r && !done_r[rd_idx_r] && (!have_r || cand_better)) begin
            best_r     <= rd_job;
            best_idx_r <= rd_idx_r;
            have_r     <= 1'b1;
          end
          if ((scan_addr_r == job_count_r) && !rd_vld_r) begin
            state_r <= S_FIN;
          end
        end

        S_FIN: begin
          fin_r   <= fin_nxt;
          clock_r <= fin_nxt;
          state_r <= S_TAT;
        end

        S_TAT: begin
          tat_r   <= fin_r - TIME_W'(best_r.arr);
          state_r <= S_WAIT;
        end

        S_WAIT: begin
          wt_r    <= (tat_r > bur_ext) ? (tat_r - bur_ext) : '0;
          state_r <= S_SUM;
        end

        S_SUM: begin
          wait_sum_r         <= wait_sum_nxt;
          done_r[best_idx_r] <= 1'b1;
          out_job_number_r   <= NUM_W'(num_wide);
          out_job_r          <= best_r;
          out_finish_r       <= fin_r;
          out_tat_r          <= tat_r;
          out_wt_r           <= wt_r;
          out_sum_r          <= wait_sum_nxt;
          out_last_r         <= last_nxt;
          out_valid_r        <= 1'b1;
          state_r            <= S_OUT;
        end

        S_OUT: begin
          if (out_xfer) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              // Set complete: return to an empty table.
              job_count_r <= '0;
              done_r      <= '0;
              clock_r     <= '0;
              wait_sum_r  <= '0;
              k_r         <= '0;
              state_r     <= S_LOAD;
            end else begin
              k_r         <= k_r + CNT_W'(1);
              scan_addr_r <= '0;
              have_r      <= 1'b0;
              state_r     <= S_SCAN;
            end
          end
        end

        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_job_number  = out_job_number_r;
  assign out_job_arrival = out_job_r.arr;
  assign out_job_burst   = out_job_r.bur;
  assign out_job_prio    = out_job_r.pri;
  assign out_finish_time = out_finish_r;
  assign out_turnaround  = out_tat_r;
  assign out_wait_time   = out_wt_r;
  assign out_wait_total  = out_sum_r;
  assign out_last_result = out_last_r;

  // Loading and result delivery never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input accepted while a result is pending");

  // The final result of a set leaves an empty table behind.
  a_set_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_result) |=> (job_count_r == '0 && done_r == '0))
    else $error("set state not cleared after final result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    job_count_r <= CNT_W'(MAX_PROCS))
    else $error("job count exceeds table depth");

  // Every scan must find a job that has not yet been scheduled.
  a_pick_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> (have_r && !done_r[best_idx_r]))
    else $error("scan ended without a pending job");

endmodule
